### rtl/canonical_kmer_quality_extractor_defines.svh
// ----------------------------------------------------------------------------
// canonical_kmer_quality_extractor_defines
// assertion macros shared by the k-mer extractor rtl
// ----------------------------------------------------------------------------
`ifndef CANONICAL_KMER_QUALITY_EXTRACTOR_DEFINES_SVH
`define CANONICAL_KMER_QUALITY_EXTRACTOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CKQE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CKQE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ckqe_pkg.sv
// ----------------------------------------------------------------------------
// ckqe_pkg
// shared types and constants of the canonical k-mer extractor
// ----------------------------------------------------------------------------
package ckqe_pkg;

  // field and register widths
  localparam int CHAR_W   = 8;
  localparam int K_W      = 6;
  localparam int CODE_W   = 2;
  localparam int OUT_W    = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // register reset values
  localparam logic [K_W-1:0]    MER_LENGTH_RST = 6'd24;
  localparam logic [CHAR_W-1:0] QUAL_THR_RST   = 8'd0;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MER_LENGTH = 2'd0,
    REG_QUAL_THR   = 2'd1
  } ckqe_reg_t;

  // nucleotide characters
  localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_C_UP = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_C_LO = 8'h63;
  localparam logic [CHAR_W-1:0] CHAR_G_UP = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_G_LO = 8'h67;
  localparam logic [CHAR_W-1:0] CHAR_T_UP = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_T_LO = 8'h74;

  // 2-bit base codes
  localparam logic [CODE_W-1:0] CODE_A = 2'd0;
  localparam logic [CODE_W-1:0] CODE_C = 2'd1;
  localparam logic [CODE_W-1:0] CODE_G = 2'd2;
  localparam logic [CODE_W-1:0] CODE_T = 2'd3;

  // one classified base as it travels from front to back
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              is_base;
    logic              high_q;
    logic              first;
  } ckqe_item_t;

endpackage

### rtl/ckqe_front.sv
// ----------------------------------------------------------------------------
// ckqe_front
// classifies one incoming base: 2-bit code, nucleotide flag, quality flag
// ----------------------------------------------------------------------------
module ckqe_front import ckqe_pkg::*; (
  input  logic [CHAR_W-1:0] base_char,
  input  logic [CHAR_W-1:0] quality_char,
  input  logic              first_of_read,
  input  logic [CHAR_W-1:0] quality_threshold,
  output ckqe_item_t        item
);

  // base decode, either case
  always_comb begin
    item.code    = CODE_A;
    item.is_base = 1'b1;
    // quality must be strictly above the threshold
    item.high_q  = (quality_char > quality_threshold);
    item.first   = first_of_read;
    unique case (base_char) inside
      CHAR_A_UP, CHAR_A_LO: item.code = CODE_A;
      CHAR_C_UP, CHAR_C_LO: item.code = CODE_C;
      CHAR_G_UP, CHAR_G_LO: item.code = CODE_G;
      CHAR_T_UP, CHAR_T_LO: item.code = CODE_T;
      default:              item.is_base = 1'b0;
    endcase
  end

endmodule

### rtl/ckqe_queue.sv
// ----------------------------------------------------------------------------
// ckqe_queue
// short fifo between classification and k-mer update
// ----------------------------------------------------------------------------
module ckqe_queue import ckqe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ckqe_item_t        push_item,
  input  logic              pop,
  output ckqe_item_t        head,
  output logic              not_empty,
  output logic              full,
  output logic [QCNT_W-1:0] count
);

  ckqe_item_t        entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == QCNT_W'(QDEPTH));

endmodule

### rtl/ckqe_back.sv
// ----------------------------------------------------------------------------
// ckqe_back
// k-mer shift registers, run counters and registered canonical result
// ----------------------------------------------------------------------------
module ckqe_back import ckqe_pkg::*; #(
  parameter int MAX_K = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [K_W-1:0]   mer_length,
  input  logic             clear_runs,
  input  ckqe_item_t       item,
  input  logic             item_valid,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] canonical_mer,
  output logic             all_high_quality
);

  localparam int             MER_W = 2 * MAX_K;
  localparam logic [K_W-1:0] K_MAX = K_W'(MAX_K);

  logic [MER_W-1:0] forward_mer;
  logic [MER_W-1:0] reverse_mer;
  logic [K_W-1:0]   valid_run;
  logic [K_W-1:0]   quality_run;

  logic [K_W-1:0]   k_eff;
  logic [MER_W-1:0] mask;
  logic [MER_W-1:0] rev_ins;
  logic [MER_W-1:0] forward_mer_next;
  logic [MER_W-1:0] reverse_mer_next;
  logic [K_W-1:0]   vr_base;
  logic [K_W-1:0]   qr_base;
  logic [K_W-1:0]   valid_run_next;
  logic [K_W-1:0]   quality_run_next;
  logic             emit;
  logic [MER_W-1:0] canon;

  // clamp k into 1..MAX_K
  always_comb begin
    if (mer_length == '0) begin
      k_eff = K_W'(1);
    end else if (mer_length > K_MAX) begin
      k_eff = K_MAX;
    end else begin
      k_eff = mer_length;
    end
  end

  // low 2k bits mask and complement placed at base position k-1
  always_comb begin
    mask    = '0;
    rev_ins = '0;
    for (int j = 0; j < MAX_K; j++) begin
      if (K_W'(j) < k_eff) begin
        mask[2*j +: 2] = 2'b11;
      end
      if (K_W'(j) == k_eff - 1'b1) begin
        rev_ins[2*j +: 2] = ~item.code;
      end
    end
  end

  // k-mer update
  assign forward_mer_next = ((forward_mer << 2) | MER_W'(item.code)) & mask;
  assign reverse_mer_next = (((reverse_mer & mask) >> 2) | rev_ins) & mask;

  // run counters, saturating at k
  always_comb begin
    vr_base = item.first ? '0 : valid_run;
    qr_base = item.first ? '0 : quality_run;
    valid_run_next = (vr_base < k_eff) ? vr_base + 1'b1 : vr_base;
    if (item.high_q) begin
      quality_run_next = (qr_base < k_eff) ? qr_base + 1'b1 : qr_base;
    end else begin
      quality_run_next = '0;
    end
  end

  // result selection
  assign emit  = item.is_base && (valid_run_next >= k_eff);
  assign canon = (forward_mer_next < reverse_mer_next) ? forward_mer_next : reverse_mer_next;

  // take the head item whenever the output register is free or draining
  assign pop = item_valid && (!out_valid || !out_stall);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      forward_mer <= '0;
      reverse_mer <= '0;
      valid_run   <= '0;
      quality_run <= '0;
    end else if (clear_runs) begin
      valid_run   <= '0;
      quality_run <= '0;
    end else if (pop) begin
      if (item.is_base) begin
        forward_mer <= forward_mer_next;
        reverse_mer <= reverse_mer_next;
        valid_run   <= valid_run_next;
        quality_run <= quality_run_next;
      end else begin
        valid_run   <= '0;
        quality_run <= '0;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      canonical_mer    <= OUT_W'(canon);
      all_high_quality <= (quality_run_next >= k_eff);
    end
  end

endmodule

### rtl/canonical_kmer_quality_extractor.sv
// ----------------------------------------------------------------------------
// canonical_kmer_quality_extractor
// streaming canonical k-mer extractor with a per-k-mer quality flag
// ----------------------------------------------------------------------------
// One base and its quality character enter per transfer. Unless the output
// stalls, one base per cycle is sustained: a base is classified on entry
// and written into a two-entry queue, and the back end takes one queue
// entry per cycle, updates the forward and reverse-complement k-mers and
// the run counters, and loads the output register, so a result appears in
// the cycle after its base is taken. A result is produced only once k
// valid bases are in place; a character other than A, C, G or T clears
// both runs and yields nothing. Input stall rises only when the queue is
// full, which happens only while the output is stalled. Writing mer_length
// clears both runs; write registers only while the block is empty.
// ----------------------------------------------------------------------------
`include "canonical_kmer_quality_extractor_defines.svh"

module canonical_kmer_quality_extractor import ckqe_pkg::*; #(
  parameter int MAX_K = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // base channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAR_W-1:0]     base_char,
  input  logic [CHAR_W-1:0]     quality_char,
  input  logic                  first_of_read,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_W-1:0]      canonical_mer,
  output logic                  all_high_quality,
  // register write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [K_W-1:0]    mer_length;
  logic [CHAR_W-1:0] quality_threshold;
  logic              cfg_xfer;
  logic              clear_runs;

  ckqe_item_t        front_item;
  ckqe_item_t        head_item;
  logic              push;
  logic              pop;
  logic              q_not_empty;
  logic              q_full;
  logic [QCNT_W-1:0] q_count;

  // register writes
  assign cfg_ready  = 1'b1;
  assign cfg_xfer   = cfg_valid && cfg_ready;
  assign clear_runs = cfg_xfer && (cfg_index == REG_MER_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      mer_length        <= MER_LENGTH_RST;
      quality_threshold <= QUAL_THR_RST;
    end else if (cfg_xfer) begin
      case (cfg_index)
        REG_MER_LENGTH: mer_length        <= cfg_data[K_W-1:0];
        REG_QUAL_THR:   quality_threshold <= cfg_data;
        default:        ;
      endcase
    end
  end

  // input transfer
  assign in_stall = q_full;
  assign push     = in_valid && !in_stall;

  ckqe_front u_front (
    .base_char         (base_char),
    .quality_char      (quality_char),
    .first_of_read     (first_of_read),
    .quality_threshold (quality_threshold),
    .item              (front_item)
  );

  ckqe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head      (head_item),
    .not_empty (q_not_empty),
    .full      (q_full),
    .count     (q_count)
  );

  ckqe_back #(
    .MAX_K (MAX_K)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .mer_length       (mer_length),
    .clear_runs       (clear_runs),
    .item             (head_item),
    .item_valid       (q_not_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .canonical_mer    (canonical_mer),
    .all_high_quality (all_high_quality)
  );

  // queue fill tracks pushes and pops
  `CKQE_ASSERT_NEXT(a_q_grow, push && !pop, q_count == $past(q_count) + 1'b1, "queue count did not grow")
  `CKQE_ASSERT_NEXT(a_q_shrink, pop && !push, q_count == $past(q_count) - 1'b1, "queue count did not shrink")
  // a new result only comes from a popped base
  `CKQE_ASSERT_NOW(a_out_from_pop, $rose(out_valid), $past(pop), "result without a popped base")
  // a held result is never overwritten by a pop
  `CKQE_ASSERT_NOW(a_no_pop_on_hold, out_valid && out_stall, !pop, "pop while result stalled")

endmodule
